// ----- hw/rtl/cbu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color blend unit package
// Shared widths, register indexes, factor and equation codes, and word types.
// ----------------------------------------------------------------------------
package cbu_pkg;

  localparam int COORD_W = 6;
  localparam int CHAN_W = 8;
  localparam int STREAM_W = 48;

  localparam int STORE_WIDTH_DEF = 64;
  localparam int STORE_HEIGHT_DEF = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_BLEND_ENABLE   = 3'd0,
    REG_SRC_FACTOR     = 3'd1,
    REG_DST_FACTOR     = 3'd2,
    REG_BLEND_EQUATION = 3'd3,
    REG_CONSTANT_COLOR = 3'd4
  } reg_index_t;

  localparam logic [3:0] FACT_ZERO                = 4'd0;
  localparam logic [3:0] FACT_ONE                 = 4'd1;
  localparam logic [3:0] FACT_SRC_COLOR           = 4'd2;
  localparam logic [3:0] FACT_ONE_MINUS_SRC_COLOR = 4'd3;
  localparam logic [3:0] FACT_DST_COLOR           = 4'd4;
  localparam logic [3:0] FACT_ONE_MINUS_DST_COLOR = 4'd5;
  localparam logic [3:0] FACT_SRC_ALPHA           = 4'd6;
  localparam logic [3:0] FACT_ONE_MINUS_SRC_ALPHA = 4'd7;
  localparam logic [3:0] FACT_DST_ALPHA           = 4'd8;
  localparam logic [3:0] FACT_ONE_MINUS_DST_ALPHA = 4'd9;
  localparam logic [3:0] FACT_CONST_COLOR         = 4'd10;
  localparam logic [3:0] FACT_ONE_MINUS_CONST     = 4'd11;
  localparam logic [3:0] FACT_CONST_ALPHA         = 4'd12;
  localparam logic [3:0] FACT_ONE_MINUS_CONST_A   = 4'd13;

  localparam logic [1:0] EQ_ADD     = 2'd0;
  localparam logic [1:0] EQ_SUB     = 2'd1;
  localparam logic [1:0] EQ_REV_SUB = 2'd2;
  localparam logic [1:0] EQ_PASS    = 2'd3;

  // Same layout as a store word: red in the high byte
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    rgba_t              color;
    logic               in_store;
  } frag_t;

  typedef struct packed {
    logic        blend_enable;
    logic [3:0]  src_factor;
    logic [3:0]  dst_factor;
    logic [1:0]  blend_equation;
    rgba_t       constant_color;
  } cfg_t;

endpackage

// ----- hw/rtl/cbu_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color blend unit front end
// Accepts fragment words, unpacks them and marks whether they hit the store.
// ----------------------------------------------------------------------------
module cbu_front #(
  parameter int STORE_WIDTH = cbu_pkg::STORE_WIDTH_DEF,
  parameter int STORE_HEIGHT = cbu_pkg::STORE_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pos_x, pos_y, frag_red, frag_green, frag_blue, frag_alpha, zero pad
  input  logic [cbu_pkg::STREAM_W-1:0]  s_axis_tdata,
  input  logic                          clear_busy,
  input  logic                          q_full,
  output logic                          q_push,
  output cbu_pkg::frag_t                q_data
);

  logic ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ready <= 1'b0;
    end else begin
      ready <= 1'b1;
    end
  end

  assign s_axis_tready = ready && !clear_busy && !q_full;
  assign q_push = s_axis_tvalid && s_axis_tready;

  always_comb begin
    q_data.x = s_axis_tdata[5:0];
    q_data.y = s_axis_tdata[11:6];
    q_data.color.red = s_axis_tdata[19:12];
    q_data.color.green = s_axis_tdata[27:20];
    q_data.color.blue = s_axis_tdata[35:28];
    q_data.color.alpha = s_axis_tdata[43:36];
    q_data.in_store = (int'(s_axis_tdata[5:0]) < STORE_WIDTH) &&
                      (int'(s_axis_tdata[11:6]) < STORE_HEIGHT);
  end

endmodule

// ----- hw/rtl/cbu_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color blend unit fragment queue
// Short circular buffer that decouples the front end from the blend pipeline.
// ----------------------------------------------------------------------------
module cbu_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cbu_pkg::frag_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output cbu_pkg::frag_t head
);

  localparam int PTR_W = (cbu_pkg::QUEUE_DEPTH > 1) ? $clog2(cbu_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(cbu_pkg::QUEUE_DEPTH + 1);

  cbu_pkg::frag_t entries [cbu_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(cbu_pkg::QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(cbu_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(cbu_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/cbu_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color blend unit back end
// Pixel store with clearing sweep, read / multiply / blend pipeline with
// write-back forwarding, and the result output register.
// ----------------------------------------------------------------------------
module cbu_back #(
  parameter int STORE_WIDTH = cbu_pkg::STORE_WIDTH_DEF,
  parameter int STORE_HEIGHT = cbu_pkg::STORE_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cbu_pkg::cfg_t                 cfg,
  input  logic                          q_valid,
  input  cbu_pkg::frag_t                q_head,
  output logic                          q_pop,
  output logic                          clear_busy,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_x, out_y, out_red, out_green, out_blue, out_alpha, zero pad
  output logic [cbu_pkg::STREAM_W-1:0]  m_axis_tdata
);

  localparam int DEPTH = STORE_WIDTH * STORE_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [7:0] factor_of(
    input logic [3:0] mode,
    input logic [7:0] s,
    input logic [7:0] d,
    input logic [7:0] k,
    input logic [7:0] sa,
    input logic [7:0] da,
    input logic [7:0] ka
  );
    case (mode)
      cbu_pkg::FACT_ZERO:                factor_of = 8'h00;
      cbu_pkg::FACT_ONE:                 factor_of = 8'hFF;
      cbu_pkg::FACT_SRC_COLOR:           factor_of = s;
      cbu_pkg::FACT_ONE_MINUS_SRC_COLOR: factor_of = ~s;
      cbu_pkg::FACT_DST_COLOR:           factor_of = d;
      cbu_pkg::FACT_ONE_MINUS_DST_COLOR: factor_of = ~d;
      cbu_pkg::FACT_SRC_ALPHA:           factor_of = sa;
      cbu_pkg::FACT_ONE_MINUS_SRC_ALPHA: factor_of = ~sa;
      cbu_pkg::FACT_DST_ALPHA:           factor_of = da;
      cbu_pkg::FACT_ONE_MINUS_DST_ALPHA: factor_of = ~da;
      cbu_pkg::FACT_CONST_COLOR:         factor_of = k;
      cbu_pkg::FACT_ONE_MINUS_CONST:     factor_of = ~k;
      cbu_pkg::FACT_CONST_ALPHA:         factor_of = ka;
      cbu_pkg::FACT_ONE_MINUS_CONST_A:   factor_of = ~ka;
      default:                           factor_of = 8'hFF;
    endcase
  endfunction

  // Round a byte product to nearest over 255
  function automatic logic [7:0] unorm_norm(input logic [15:0] p);
    logic [16:0] t;
    logic [16:0] sum;
    t = {1'b0, p} + 17'd128;
    sum = t + (t >> 8);
    unorm_norm = sum[15:8];
  endfunction

  logic [31:0] store [DEPTH];

  logic              clr_busy;
  logic [ADDR_W-1:0] clr_addr;

  logic              adv;
  logic              hazard;
  logic              issue;
  logic [ADDR_W-1:0] issue_addr;

  logic              s1_valid;
  cbu_pkg::frag_t    s1_frag;
  logic [ADDR_W-1:0] s1_addr;
  logic [31:0]       rd_data;

  logic              wb_valid;
  logic [5:0]        wb_x;
  logic [5:0]        wb_y;
  logic [31:0]       wb_data;

  logic              s2_valid;
  cbu_pkg::frag_t    s2_frag;
  logic [ADDR_W-1:0] s2_addr;
  logic [3:0][15:0]  s2_ps;
  logic [3:0][15:0]  s2_pd;

  logic              out_valid;
  logic [5:0]        out_x;
  logic [5:0]        out_y;
  cbu_pkg::rgba_t    out_color;

  logic [3:0][15:0]  prod_s;
  logic [3:0][15:0]  prod_d;
  logic [31:0]       dst_word;
  cbu_pkg::rgba_t    result;

  assign clear_busy = clr_busy;
  assign adv = !out_valid || m_axis_tready;
  assign hazard = s1_valid && s1_frag.in_store && q_head.in_store &&
                  (q_head.x == s1_frag.x) && (q_head.y == s1_frag.y);
  assign issue = adv && q_valid && !clr_busy && !hazard;
  assign q_pop = issue;
  assign issue_addr = q_head.in_store ?
                      ADDR_W'(int'(q_head.y) * STORE_WIDTH + int'(q_head.x)) : '0;

  // Clear the store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      store[clr_addr] <= '0;
    end else if (adv && s2_valid && s2_frag.in_store) begin
      store[s2_addr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data <= store[issue_addr];
    end
  end

  // Multiply stage: forward the write that landed with this read
  always_comb begin
    logic [3:0][7:0] sc;
    logic [3:0][7:0] dc;
    logic [3:0][7:0] kc;
    logic [7:0]      fs;
    logic [7:0]      fd;
    if (!s1_frag.in_store) begin
      dst_word = '0;
    end else if (wb_valid && (wb_x == s1_frag.x) && (wb_y == s1_frag.y)) begin
      dst_word = wb_data;
    end else begin
      dst_word = rd_data;
    end
    sc = s1_frag.color;
    dc = dst_word;
    kc = cfg.constant_color;
    for (int ch = 0; ch < 4; ch++) begin
      fs = factor_of(cfg.src_factor, sc[ch], dc[ch], kc[ch], sc[0], dc[0], kc[0]);
      fd = factor_of(cfg.dst_factor, sc[ch], dc[ch], kc[ch], sc[0], dc[0], kc[0]);
      prod_s[ch] = 16'(sc[ch]) * 16'(fs);
      prod_d[ch] = 16'(dc[ch]) * 16'(fd);
    end
  end

  // Blend stage: normalize, combine, clamp
  always_comb begin
    logic [3:0][7:0] sc;
    logic [3:0][7:0] rc;
    logic [7:0]      a;
    logic [7:0]      b;
    logic [8:0]      sum;
    sc = s2_frag.color;
    for (int ch = 0; ch < 4; ch++) begin
      a = unorm_norm(s2_ps[ch]);
      b = unorm_norm(s2_pd[ch]);
      sum = {1'b0, a} + {1'b0, b};
      if (!cfg.blend_enable) begin
        rc[ch] = sc[ch];
      end else begin
        case (cfg.blend_equation)
          cbu_pkg::EQ_ADD:     rc[ch] = sum[8] ? 8'hFF : sum[7:0];
          cbu_pkg::EQ_SUB:     rc[ch] = (a > b) ? a - b : 8'h00;
          cbu_pkg::EQ_REV_SUB: rc[ch] = (b > a) ? b - a : 8'h00;
          default:             rc[ch] = sc[ch];
        endcase
      end
    end
    result = rc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      wb_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      wb_valid <= s2_valid && s2_frag.in_store;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_frag <= q_head;
      s1_addr <= issue_addr;
      s2_frag <= s1_frag;
      s2_addr <= s1_addr;
      s2_ps <= prod_s;
      s2_pd <= prod_d;
      wb_x <= s2_frag.x;
      wb_y <= s2_frag.y;
      wb_data <= result;
      out_x <= s2_frag.x;
      out_y <= s2_frag.y;
      out_color <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {4'b0000, out_color.alpha, out_color.blue, out_color.green,
                         out_color.red, out_y, out_x};

endmodule

// ----- hw/rtl/color_blend_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color blend unit
// Blends RGBA8 fragments into a pixel store and emits each written pixel.
//
// channel   dir  handshake                  width
// s_axis    in   tvalid / tready            48   fragment word
// m_axis    out  tvalid / tready            48   written pixel word
// apb       in   psel / penable / pready    32   blend registers
//
// One fragment per cycle sustained while m_axis is ready; a fragment at the same
// pixel as the one just before it waits at the store read port. After reset the
// store is swept to zero, all STORE_WIDTH*STORE_HEIGHT words (4096 by default),
// with s_axis_tready low. A stalled m_axis freezes the blend pipeline; the queue
// keeps taking fragments until it fills.
// ----------------------------------------------------------------------------
module color_blend_unit #(
  parameter int STORE_WIDTH = cbu_pkg::STORE_WIDTH_DEF,
  parameter int STORE_HEIGHT = cbu_pkg::STORE_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pos_x, pos_y, frag_red, frag_green, frag_blue, frag_alpha, zero pad
  input  logic [cbu_pkg::STREAM_W-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_x, out_y, out_red, out_green, out_blue, out_alpha, zero pad
  output logic [cbu_pkg::STREAM_W-1:0]    m_axis_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cbu_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [cbu_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [cbu_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  logic           blend_enable;
  logic [3:0]     src_factor;
  logic [3:0]     dst_factor;
  logic [1:0]     blend_equation;
  logic [31:0]    constant_color;
  logic           cfg_write;
  cbu_pkg::cfg_t  cfg;

  logic           clear_busy;
  logic           q_full;
  logic           q_push;
  cbu_pkg::frag_t q_data;
  logic           q_pop;
  logic           q_valid;
  cbu_pkg::frag_t q_head;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_enable <= 1'b0;
      src_factor <= cbu_pkg::FACT_SRC_ALPHA;
      dst_factor <= cbu_pkg::FACT_ONE_MINUS_SRC_ALPHA;
      blend_equation <= cbu_pkg::EQ_ADD;
      constant_color <= 32'hFFFF_FFFF;
    end else if (cfg_write) begin
      case (cbu_pkg::reg_index_t'(paddr[cbu_pkg::CFG_ADDR_W-1:2]))
        cbu_pkg::REG_BLEND_ENABLE:   blend_enable <= pwdata[0];
        cbu_pkg::REG_SRC_FACTOR:     src_factor <= pwdata[3:0];
        cbu_pkg::REG_DST_FACTOR:     dst_factor <= pwdata[3:0];
        cbu_pkg::REG_BLEND_EQUATION: blend_equation <= pwdata[1:0];
        cbu_pkg::REG_CONSTANT_COLOR: constant_color <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cbu_pkg::reg_index_t'(paddr[cbu_pkg::CFG_ADDR_W-1:2]))
      cbu_pkg::REG_BLEND_ENABLE:   prdata = {31'b0, blend_enable};
      cbu_pkg::REG_SRC_FACTOR:     prdata = {28'b0, src_factor};
      cbu_pkg::REG_DST_FACTOR:     prdata = {28'b0, dst_factor};
      cbu_pkg::REG_BLEND_EQUATION: prdata = {30'b0, blend_equation};
      cbu_pkg::REG_CONSTANT_COLOR: prdata = constant_color;
      default:                     prdata = '0;
    endcase
  end

  always_comb begin
    cfg.blend_enable = blend_enable;
    cfg.src_factor = src_factor;
    cfg.dst_factor = dst_factor;
    cfg.blend_equation = blend_equation;
    cfg.constant_color = constant_color;
  end

  cbu_front #(
    .STORE_WIDTH(STORE_WIDTH),
    .STORE_HEIGHT(STORE_HEIGHT)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .clear_busy(clear_busy),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(q_data)
  );

  cbu_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_data(q_data),
    .full(q_full),
    .pop(q_pop),
    .valid(q_valid),
    .head(q_head)
  );

  cbu_back #(
    .STORE_WIDTH(STORE_WIDTH),
    .STORE_HEIGHT(STORE_HEIGHT)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_valid(q_valid),
    .q_head(q_head),
    .q_pop(q_pop),
    .clear_busy(clear_busy),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> !s_axis_tready)
    else $error("fragment accepted during store clear");

  a_empty_in_clear: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> (!q_valid && !m_axis_tvalid))
    else $error("work in flight during store clear");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

// ----- dv/color_blend_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color blend unit checker
// Tracks the blend registers from APB writes and keeps a private copy of the
// pixel store. Each fragment word taken on s_axis is blended into that copy,
// and the written pixel is queued. Each m_axis word is compared field by
// field against the oldest queued pixel.
// ----------------------------------------------------------------------------
module color_blend_unit_checker #(
  parameter int STORE_WIDTH = cbu_pkg::STORE_WIDTH_DEF,
  parameter int STORE_HEIGHT = cbu_pkg::STORE_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  // pos_x, pos_y, frag_red, frag_green, frag_blue, frag_alpha, zero pad
  input  logic [cbu_pkg::STREAM_W-1:0]    s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_x, out_y, out_red, out_green, out_blue, out_alpha, zero pad
  input  logic [cbu_pkg::STREAM_W-1:0]    m_axis_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cbu_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [cbu_pkg::CFG_DATA_W-1:0]  pwdata,
  input  logic                            pready,
  output int                              pending,
  output int                              fail_count
);

  localparam int STORE_DEPTH = STORE_WIDTH * STORE_HEIGHT;
  localparam int SW = cbu_pkg::STREAM_W;

  typedef struct packed {
    logic [3:0]                  pad;
    logic [cbu_pkg::CHAN_W-1:0]  alpha;
    logic [cbu_pkg::CHAN_W-1:0]  blue;
    logic [cbu_pkg::CHAN_W-1:0]  green;
    logic [cbu_pkg::CHAN_W-1:0]  red;
    logic [cbu_pkg::COORD_W-1:0] y;
    logic [cbu_pkg::COORD_W-1:0] x;
  } pixel_word_t;

  cbu_pkg::cfg_t  blend_regs;
  cbu_pkg::rgba_t store_copy [STORE_DEPTH];
  pixel_word_t    expected_pixels [$];
  int             mismatch_count = 0;

  task automatic report_mismatch(string what, logic [SW-1:0] got, logic [SW-1:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [cbu_pkg::CHAN_W-1:0] channel_of(cbu_pkg::rgba_t c, int ch);
    logic [31:0] w;
    w = c;
    return w[(3 - ch) * 8 +: 8];
  endfunction

  function automatic logic [cbu_pkg::CHAN_W-1:0] factor_for(logic [3:0] mode, int ch,
                                                            cbu_pkg::rgba_t src,
                                                            cbu_pkg::rgba_t dst,
                                                            cbu_pkg::rgba_t konst);
    case (mode)
      cbu_pkg::FACT_ZERO:                return 8'd0;
      cbu_pkg::FACT_ONE:                 return 8'd255;
      cbu_pkg::FACT_SRC_COLOR:           return channel_of(src, ch);
      cbu_pkg::FACT_ONE_MINUS_SRC_COLOR: return 8'd255 - channel_of(src, ch);
      cbu_pkg::FACT_DST_COLOR:           return channel_of(dst, ch);
      cbu_pkg::FACT_ONE_MINUS_DST_COLOR: return 8'd255 - channel_of(dst, ch);
      cbu_pkg::FACT_SRC_ALPHA:           return src.alpha;
      cbu_pkg::FACT_ONE_MINUS_SRC_ALPHA: return 8'd255 - src.alpha;
      cbu_pkg::FACT_DST_ALPHA:           return dst.alpha;
      cbu_pkg::FACT_ONE_MINUS_DST_ALPHA: return 8'd255 - dst.alpha;
      cbu_pkg::FACT_CONST_COLOR:         return channel_of(konst, ch);
      cbu_pkg::FACT_ONE_MINUS_CONST:     return 8'd255 - channel_of(konst, ch);
      cbu_pkg::FACT_CONST_ALPHA:         return konst.alpha;
      cbu_pkg::FACT_ONE_MINUS_CONST_A:   return 8'd255 - konst.alpha;
      default:                           return 8'd255;
    endcase
  endfunction

  function automatic int unorm_scale(logic [cbu_pkg::CHAN_W-1:0] a,
                                     logic [cbu_pkg::CHAN_W-1:0] f);
    return (int'(a) * int'(f) + 127) / 255;
  endfunction

  // Blend one fragment into the store copy and return the written pixel
  function automatic pixel_word_t blend_pixel(pixel_word_t frag);
    pixel_word_t    written;
    cbu_pkg::rgba_t src;
    cbu_pkg::rgba_t dst;
    logic [31:0]    color;
    int             sv;
    int             dv;
    int             r;
    int             addr;
    int             ch;
    bit             on_store;
    src = {frag.red, frag.green, frag.blue, frag.alpha};
    on_store = (int'(frag.x) < STORE_WIDTH) && (int'(frag.y) < STORE_HEIGHT);
    addr = on_store ? int'(frag.y) * STORE_WIDTH + int'(frag.x) : 0;
    dst = on_store ? store_copy[addr] : '0;
    for (ch = 0; ch < 4; ch++) begin
      if (!blend_regs.blend_enable || blend_regs.blend_equation == cbu_pkg::EQ_PASS) begin
        r = int'(channel_of(src, ch));
      end else begin
        sv = unorm_scale(channel_of(src, ch),
                         factor_for(blend_regs.src_factor, ch, src, dst,
                                    blend_regs.constant_color));
        dv = unorm_scale(channel_of(dst, ch),
                         factor_for(blend_regs.dst_factor, ch, src, dst,
                                    blend_regs.constant_color));
        case (blend_regs.blend_equation)
          cbu_pkg::EQ_ADD: r = (sv + dv > 255) ? 255 : sv + dv;
          cbu_pkg::EQ_SUB: r = (sv > dv) ? sv - dv : 0;
          default:         r = (dv > sv) ? dv - sv : 0;
        endcase
      end
      color[(3 - ch) * 8 +: 8] = r[7:0];
    end
    if (on_store) store_copy[addr] = color;
    written = '0;
    written.x = frag.x;
    written.y = frag.y;
    {written.red, written.green, written.blue, written.alpha} = color;
    return written;
  endfunction

  always @(posedge clk) begin
    pixel_word_t got;
    pixel_word_t want;
    if (rst) begin
      blend_regs.blend_enable = 1'b0;
      blend_regs.src_factor = cbu_pkg::FACT_SRC_ALPHA;
      blend_regs.dst_factor = cbu_pkg::FACT_ONE_MINUS_SRC_ALPHA;
      blend_regs.blend_equation = cbu_pkg::EQ_ADD;
      blend_regs.constant_color = 32'hFFFF_FFFF;
      for (int i = 0; i < STORE_DEPTH; i++) store_copy[i] = '0;
      expected_pixels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cbu_pkg::reg_index_t'(paddr[cbu_pkg::CFG_ADDR_W-1:2]))
          cbu_pkg::REG_BLEND_ENABLE:   blend_regs.blend_enable = pwdata[0];
          cbu_pkg::REG_SRC_FACTOR:     blend_regs.src_factor = pwdata[3:0];
          cbu_pkg::REG_DST_FACTOR:     blend_regs.dst_factor = pwdata[3:0];
          cbu_pkg::REG_BLEND_EQUATION: blend_regs.blend_equation = pwdata[1:0];
          cbu_pkg::REG_CONSTANT_COLOR: blend_regs.constant_color = pwdata;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_pixels.size() == 0) begin
          report_mismatch("result word with none pending", got, '0);
        end else begin
          want = expected_pixels.pop_front();
          if (got.x !== want.x) report_mismatch("out_x", SW'(got.x), SW'(want.x));
          if (got.y !== want.y) report_mismatch("out_y", SW'(got.y), SW'(want.y));
          if (got.red !== want.red)
            report_mismatch("out_red", SW'(got.red), SW'(want.red));
          if (got.green !== want.green)
            report_mismatch("out_green", SW'(got.green), SW'(want.green));
          if (got.blue !== want.blue)
            report_mismatch("out_blue", SW'(got.blue), SW'(want.blue));
          if (got.alpha !== want.alpha)
            report_mismatch("out_alpha", SW'(got.alpha), SW'(want.alpha));
        end
      end
      if (s_axis_tvalid && s_axis_tready) expected_pixels.push_back(blend_pixel(s_axis_tdata));
    end
    pending <= expected_pixels.size();
    fail_count <= mismatch_count;
  end

endmodule

// ----- dv/color_blend_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color blend unit testbench
// Drives fragment words and blend register writes into the unit, stalls the
// result side at random, and leaves prediction and comparison to the checker.
// A directed pass walks every factor code and equation, then random phases
// with fresh register settings blend mostly into a small corner of the store.
// ----------------------------------------------------------------------------
module color_blend_unit_test;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_WORDS = 50;

  logic                           clk;
  logic                           rst;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [cbu_pkg::STREAM_W-1:0]   s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [cbu_pkg::STREAM_W-1:0]   m_axis_tdata;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [cbu_pkg::CFG_ADDR_W-1:0] paddr;
  logic [cbu_pkg::CFG_DATA_W-1:0] pwdata;
  logic [cbu_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  int                             pending;
  int                             failures;
  int                             stall_cycles = 0;
  bit                             steady = 1'b0;
  logic [cbu_pkg::COORD_W-1:0]    last_x = '0;
  logic [cbu_pkg::COORD_W-1:0]    last_y = '0;

  color_blend_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  color_blend_unit_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .pending       (pending),
    .fail_count    (failures)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(cbu_pkg::reg_index_t idx, logic [cbu_pkg::CFG_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_blend(logic enable, logic [3:0] src, logic [3:0] dst, logic [1:0] eq,
                           logic [31:0] konst);
    write_reg(cbu_pkg::REG_BLEND_ENABLE, {31'd0, enable});
    write_reg(cbu_pkg::REG_SRC_FACTOR, {28'd0, src});
    write_reg(cbu_pkg::REG_DST_FACTOR, {28'd0, dst});
    write_reg(cbu_pkg::REG_BLEND_EQUATION, {30'd0, eq});
    write_reg(cbu_pkg::REG_CONSTANT_COLOR, konst);
  endtask

  // Drop valid and hold until every predicted pixel has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_word(logic [cbu_pkg::STREAM_W-1:0] word);
    while (!steady && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic [cbu_pkg::STREAM_W-1:0] make_frag(
    logic [cbu_pkg::COORD_W-1:0] x,
    logic [cbu_pkg::COORD_W-1:0] y,
    logic [cbu_pkg::CHAN_W-1:0]  r,
    logic [cbu_pkg::CHAN_W-1:0]  g,
    logic [cbu_pkg::CHAN_W-1:0]  b,
    logic [cbu_pkg::CHAN_W-1:0]  a
  );
    return {4'd0, a, b, g, r, y, x};
  endfunction

  // Mostly a small corner of the store so pixels get blended repeatedly
  function automatic logic [cbu_pkg::STREAM_W-1:0] random_frag();
    logic [31:0] color;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick >= 15 && pick < 60) begin
      last_x = 6'($urandom_range(0, 3));
      last_y = 6'($urandom_range(0, 3));
    end else if (pick >= 60) begin
      last_x = 6'($urandom);
      last_y = 6'($urandom);
    end
    color = $urandom;
    for (int ch = 0; ch < 4; ch++) begin
      if ($urandom_range(0, 99) < 10) color[ch * 8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return make_frag(last_x, last_y, color[31:24], color[23:16], color[15:8], color[7:0]);
  endfunction

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Blending off after reset: lay down known pixels, same pixel back to back
    send_word(make_frag(6'd0, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_word(make_frag(6'd63, 6'd63, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_frag(6'd1, 6'd0, 8'h80, 8'h40, 8'hC0, 8'h7F));
    send_word(make_frag(6'd1, 6'd0, 8'h3C, 8'hE1, 8'h0F, 8'hA5));
    wait_drained();

    // Walk every factor code on both sides and every equation code
    for (int mode = 0; mode < 16; mode++) begin
      set_blend(1'b1, 4'(mode), 4'(15 - mode), 2'(mode % 4), $urandom);
      send_word(make_frag(6'd1, 6'd0, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom)));
      wait_drained();
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: set_blend(1'b0, cbu_pkg::FACT_ZERO, cbu_pkg::FACT_ZERO, cbu_pkg::EQ_ADD,
                     32'h0000_0000);
        1: set_blend(1'b1, 4'hF, 4'hF, cbu_pkg::EQ_PASS, 32'hFFFF_FFFF);
        2: set_blend(1'b1, cbu_pkg::FACT_ONE_MINUS_CONST_A, cbu_pkg::FACT_ONE_MINUS_CONST_A,
                     cbu_pkg::EQ_REV_SUB, 32'hFFFF_FFFF);
        default: set_blend($urandom_range(0, 99) < 85, 4'($urandom_range(0, 15)),
                           4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                           ($urandom_range(0, 99) < 20) ? {32{1'($urandom)}} : $urandom);
      endcase
      steady <= (phase == 4 || phase == 7);
      repeat (PHASE_WORDS) send_word(random_frag());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
